[src/sbc_pkg.sv]
// ----------------------------------------------------------------------------
// Skip-bigram counter package
// Shared constants, payload structs, queue entry and sequencer state types.
// ----------------------------------------------------------------------------
package sbc_pkg;

   // Default sizes for the top-level parameters.
   localparam int DEF_OFFSETS    = 16;
   localparam int DEF_COUNT_BITS = 32;

   // Fixed field widths.
   localparam int BYTE_BITS = 8;
   localparam int OUT_BITS  = 32;

   // Depth of the queue between the front and back ends (a power of two).
   localparam int QUEUE_DEPTH = 2;

   // Action codes of an input item.
   localparam logic ACT_PUSH = 1'b0;
   localparam logic ACT_READ = 1'b1;

   // Input item.
   typedef struct packed {
      logic                 action;
      logic [BYTE_BITS-1:0] byte_value;
      logic [3:0]           read_offset;
      logic [BYTE_BITS-1:0] read_prior;
      logic [BYTE_BITS-1:0] read_next;
   } sbc_req_type;

   // Result item.
   typedef struct packed {
      logic [OUT_BITS-1:0] pair_count;
      logic [OUT_BITS-1:0] row_count;
   } sbc_rsp_type;

   // Operation class assigned by the front end.
   typedef enum logic [1:0] {
      OP_PUSH,
      OP_READ,
      OP_READ_NONE
   } sbc_op_type;

   // Queue entry handed from the front end to the back end.
   typedef struct packed {
      sbc_op_type           op;
      logic [BYTE_BITS-1:0] byte_value;
      logic [3:0]           read_offset;
      logic [BYTE_BITS-1:0] read_prior;
      logic [BYTE_BITS-1:0] read_next;
   } sbc_entry_type;

   // Back-end sequencer states.
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PUSH,
      ST_DRAIN,
      ST_READ
   } sbc_state_type;

endpackage

[src/sbc_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sbc_ram #(
   parameter int WIDTH     = 32,
   parameter int DEPTH     = 4096,
   parameter int ADDR_BITS = 12
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[src/sbc_queue.sv]
// ----------------------------------------------------------------------------
// Skip-bigram counter queue
// Short FIFO of classified items between the front end and the back end.
// ----------------------------------------------------------------------------
module sbc_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   output logic                  push_ready,
   input  sbc_pkg::sbc_entry_type push_entry,
   output logic                  pop_valid,
   input  logic                  pop_ready,
   output sbc_pkg::sbc_entry_type pop_entry
);

   import sbc_pkg::*;

   localparam int PTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int COUNT_BITS = $clog2(QUEUE_DEPTH + 1);

   sbc_entry_type         entries_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  do_push;
   logic                  do_pop;

   // Handshake status.
   assign push_ready = (count_ff != COUNT_BITS'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Pointer and occupancy update; the depth is a power of two, so pointers wrap.
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + COUNT_BITS'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - COUNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

[src/sbc_front.sv]
// ----------------------------------------------------------------------------
// Skip-bigram counter front end
// Accepts input items and classifies them into queue entries.
// ----------------------------------------------------------------------------
module sbc_front #(
   parameter int OFFSETS = sbc_pkg::DEF_OFFSETS
) (
   input  logic                   req_valid,
   output logic                   req_ready,
   input  sbc_pkg::sbc_req_type   req_data,
   input  logic                   clear_busy,
   output logic                   push_valid,
   input  logic                   push_ready,
   output sbc_pkg::sbc_entry_type push_entry
);

   import sbc_pkg::*;

   logic offset_in_range;

   // Items wait while the counter memories are being cleared.
   assign req_ready  = push_ready && !clear_busy;
   assign push_valid = req_valid && !clear_busy;

   // A read beyond the configured offsets needs no memory access.
   assign offset_in_range = (32'(req_data.read_offset) < 32'(OFFSETS));

   // Classification.
   always_comb begin
      push_entry.byte_value  = req_data.byte_value;
      push_entry.read_offset = req_data.read_offset;
      push_entry.read_prior  = req_data.read_prior;
      push_entry.read_next   = req_data.read_next;
      if (req_data.action == ACT_PUSH) begin
         push_entry.op = OP_PUSH;
      end else if (offset_in_range) begin
         push_entry.op = OP_READ;
      end else begin
         push_entry.op = OP_READ_NONE;
      end
   end

endmodule

[src/sbc_back.sv]
// ----------------------------------------------------------------------------
// Skip-bigram counter back end
// Keeps the byte history, runs the counter read-modify-write sequence,
// answers reads and clears the counter memories after reset.
// ----------------------------------------------------------------------------
module sbc_back #(
   parameter int OFFSETS    = sbc_pkg::DEF_OFFSETS,
   parameter int COUNT_BITS = sbc_pkg::DEF_COUNT_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   pop_valid,
   output logic                   pop_ready,
   input  sbc_pkg::sbc_entry_type pop_entry,
   output logic                   clear_busy,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output sbc_pkg::sbc_rsp_type   rsp_data
);

   import sbc_pkg::*;

   localparam int OFF_BITS   = (OFFSETS > 1) ? $clog2(OFFSETS) : 1;
   localparam int FILL_BITS  = $clog2(OFFSETS + 1);
   localparam int ROW_BITS   = OFF_BITS + BYTE_BITS;
   localparam int PAIR_BITS  = OFF_BITS + 2 * BYTE_BITS;
   localparam int ROW_DEPTH  = OFFSETS * 256;
   localparam int PAIR_DEPTH = OFFSETS * 65536;
   localparam logic [COUNT_BITS-1:0] OUT_LIMIT = COUNT_BITS'({OUT_BITS{1'b1}});

   sbc_state_type         state_ff, state_in;
   logic [BYTE_BITS-1:0]  hist_ff [OFFSETS];
   logic [BYTE_BITS-1:0]  hist_in [OFFSETS];
   logic [BYTE_BITS-1:0]  work_ff [OFFSETS];
   logic [BYTE_BITS-1:0]  work_in [OFFSETS];
   logic [FILL_BITS-1:0]  fill_ff, fill_in;
   logic [BYTE_BITS-1:0]  cur_ff, cur_in;
   logic [OFF_BITS-1:0]   step_ff, step_in;
   logic [OFF_BITS-1:0]   last_ff, last_in;
   logic                  wr_pend_ff, wr_pend_in;
   logic [PAIR_BITS-1:0]  wr_pair_addr_ff, wr_pair_addr_in;
   logic [ROW_BITS-1:0]   wr_row_addr_ff, wr_row_addr_in;
   logic [PAIR_BITS-1:0]  clr_ff, clr_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   sbc_rsp_type           rsp_data_ff, rsp_data_in;

   logic                  rsp_free;
   logic                  take;
   logic [OFF_BITS-1:0]   req_off;
   logic [PAIR_BITS-1:0]  rd_pair_addr;
   logic [ROW_BITS-1:0]   rd_row_addr;
   logic [COUNT_BITS-1:0] pair_rd_data;
   logic [COUNT_BITS-1:0] row_rd_data;
   logic                  pair_wr_en;
   logic [PAIR_BITS-1:0]  pair_wr_addr;
   logic [COUNT_BITS-1:0] pair_wr_data;
   logic                  row_wr_en;
   logic [ROW_BITS-1:0]   row_wr_addr;
   logic [COUNT_BITS-1:0] row_wr_data;

   // Saturating increment of one counter.
   function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] value);
      return (value == '1) ? value : value + COUNT_BITS'(1);
   endfunction

   // Limit a counter value to the result field width.
   function automatic logic [OUT_BITS-1:0] clamp_out(input logic [COUNT_BITS-1:0] value);
      logic [OUT_BITS-1:0] result;
      if (COUNT_BITS > OUT_BITS && value > OUT_LIMIT) begin
         result = '1;
      end else begin
         result = OUT_BITS'(value);
      end
      return result;
   endfunction

   assign rsp_free   = !rsp_valid_ff || rsp_ready;
   assign take       = pop_valid && pop_ready;
   assign clear_busy = (state_ff == ST_CLEAR);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign req_off    = OFF_BITS'(pop_entry.read_offset);

   // Read addresses: the current offset step while pushing, the request otherwise.
   always_comb begin
      if (state_ff == ST_PUSH) begin
         rd_pair_addr = {step_ff, work_ff[0], cur_ff};
         rd_row_addr  = {step_ff, work_ff[0]};
      end else begin
         rd_pair_addr = {req_off, pop_entry.read_prior, pop_entry.read_next};
         rd_row_addr  = {req_off, pop_entry.read_prior};
      end
   end

   // Write ports: zeros during the clearing pass, incremented counters otherwise.
   always_comb begin
      if (state_ff == ST_CLEAR) begin
         pair_wr_en   = 1'b1;
         pair_wr_addr = clr_ff;
         pair_wr_data = '0;
         row_wr_en    = 1'b1;
         row_wr_addr  = clr_ff[PAIR_BITS-1:BYTE_BITS];
         row_wr_data  = '0;
      end else begin
         pair_wr_en   = wr_pend_ff;
         pair_wr_addr = wr_pair_addr_ff;
         pair_wr_data = sat_inc(pair_rd_data);
         row_wr_en    = wr_pend_ff;
         row_wr_addr  = wr_row_addr_ff;
         row_wr_data  = sat_inc(row_rd_data);
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == PAIR_BITS'(PAIR_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (take) begin
               case (pop_entry.op)
                  OP_PUSH: begin
                     if (fill_ff != '0) begin
                        state_in = ST_PUSH;
                     end
                  end
                  OP_READ: begin
                     state_in = ST_READ;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_PUSH: begin
            if (step_ff == last_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_IDLE;
         end
         ST_READ: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs and datapath next values.
   always_comb begin
      pop_ready       = 1'b0;
      hist_in         = hist_ff;
      work_in         = work_ff;
      fill_in         = fill_ff;
      cur_in          = cur_ff;
      step_in         = step_ff;
      last_in         = last_ff;
      wr_pend_in      = 1'b0;
      wr_pair_addr_in = rd_pair_addr;
      wr_row_addr_in  = rd_row_addr;
      clr_in          = clr_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_data_in     = rsp_data_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + PAIR_BITS'(1);
         end
         ST_IDLE: begin
            // Reads wait until the result register can take their answer.
            case (pop_entry.op)
               OP_PUSH: pop_ready = 1'b1;
               default: pop_ready = rsp_free;
            endcase
            if (take) begin
               case (pop_entry.op)
                  OP_PUSH: begin
                     // Snapshot the history for the offset walk, then shift in the byte.
                     work_in    = hist_ff;
                     hist_in[0] = pop_entry.byte_value;
                     for (int g = 1; g < OFFSETS; g++) begin
                        hist_in[g] = hist_ff[g-1];
                     end
                     if (fill_ff != FILL_BITS'(OFFSETS)) begin
                        fill_in = fill_ff + FILL_BITS'(1);
                     end
                     cur_in  = pop_entry.byte_value;
                     step_in = '0;
                     last_in = OFF_BITS'(fill_ff - FILL_BITS'(1));
                  end
                  OP_READ_NONE: begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = '0;
                  end
                  default: begin
                     rsp_valid_in = rsp_valid_ff && !rsp_ready;
                  end
               endcase
            end
         end
         ST_PUSH: begin
            // One offset per cycle; its write-back follows in the next cycle.
            wr_pend_in = 1'b1;
            step_in    = step_ff + OFF_BITS'(1);
            for (int g = 0; g < OFFSETS - 1; g++) begin
               work_in[g] = work_ff[g+1];
            end
         end
         ST_READ: begin
            rsp_valid_in           = 1'b1;
            rsp_data_in.pair_count = clamp_out(pair_rd_data);
            rsp_data_in.row_count  = clamp_out(row_rd_data);
         end
         default: begin
            pop_ready = 1'b0;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         fill_ff      <= '0;
         wr_pend_ff   <= 1'b0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int g = 0; g < OFFSETS; g++) begin
            hist_ff[g] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         wr_pend_ff   <= wr_pend_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         hist_ff      <= hist_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      work_ff         <= work_in;
      cur_ff          <= cur_in;
      step_ff         <= step_in;
      last_ff         <= last_in;
      wr_pair_addr_ff <= wr_pair_addr_in;
      wr_row_addr_ff  <= wr_row_addr_in;
      rsp_data_ff     <= rsp_data_in;
   end

   // Pair counters, addressed by offset, earlier byte and later byte.
   sbc_ram #(
      .WIDTH     (COUNT_BITS),
      .DEPTH     (PAIR_DEPTH),
      .ADDR_BITS (PAIR_BITS)
   ) u_pair_ram (
      .clock   (clock),
      .wr_en   (pair_wr_en),
      .wr_addr (pair_wr_addr),
      .wr_data (pair_wr_data),
      .rd_addr (rd_pair_addr),
      .rd_data (pair_rd_data)
   );

   // Row totals, addressed by offset and earlier byte.
   sbc_ram #(
      .WIDTH     (COUNT_BITS),
      .DEPTH     (ROW_DEPTH),
      .ADDR_BITS (ROW_BITS)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (row_wr_en),
      .wr_addr (row_wr_addr),
      .wr_data (row_wr_data),
      .rd_addr (rd_row_addr),
      .rd_data (row_rd_data)
   );

endmodule

[src/skip_bigram_counter.sv]
// Push with filled history slots: the accept cycle, one read-modify-write of the pair and row
//   memories per filled offset and one write-back.
// Push while the history is empty: accepted with no memory access.
// Read: memory read, then result register; out-of-range read: zero result, no memory access.
// The two-entry queue registers each item ahead of the back end.
// Reset clears history and control at once, then a clearing pass over all OFFSETS * 65536 pair
//   addresses (1048576 by default) zeroes both counter memories; req_ready stays low during it.
// ----------------------------------------------------------------------------
// Skip-bigram counter
// Streams bytes and counts skip-bigram pairs and row totals per offset.
// ----------------------------------------------------------------------------
module skip_bigram_counter #(
   parameter int OFFSETS    = sbc_pkg::DEF_OFFSETS,
   parameter int COUNT_BITS = sbc_pkg::DEF_COUNT_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  sbc_pkg::sbc_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output sbc_pkg::sbc_rsp_type rsp_data
);

   import sbc_pkg::*;

   logic          clear_busy;
   logic          push_valid;
   logic          push_ready;
   sbc_entry_type push_entry;
   logic          pop_valid;
   logic          pop_ready;
   sbc_entry_type pop_entry;

   // Front end: acceptance and classification.
   sbc_front #(
      .OFFSETS (OFFSETS)
   ) u_front (
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .clear_busy (clear_busy),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   // Queue between the two ends.
   sbc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   // Back end: history, counter updates and reads.
   sbc_back #(
      .OFFSETS    (OFFSETS),
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry),
      .clear_busy (clear_busy),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule
